>>> hdl/hrlt_pkg.sv
// Shared types, character constants and lookup functions for the request line tokenizer.
`timescale 1ns / 1ps

package hrlt_pkg;

  localparam int LEXEME_BYTES_DEF = 32;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [3:0] {
    K_GET       = 4'd0,
    K_PATH      = 4'd1,
    K_VERSION   = 4'd2,
    K_EOL       = 4'd3,
    K_EOH       = 4'd4,
    K_CHUNK     = 4'd5,
    K_BAD_CHAR  = 4'd6,
    K_BAD_FIRST = 4'd7,
    K_TOO_LONG  = 4'd8,
    K_CRLF_ERR  = 4'd9,
    K_IO_ERR    = 4'd10,
    K_EOF       = 4'd11
  } tok_kind_t;

  typedef enum logic [2:0] {
    C_METHOD  = 3'd0,
    C_PATH    = 3'd1,
    C_VERSION = 3'd2,
    C_EOL     = 3'd3,
    C_EOH     = 3'd4,
    C_CHARS   = 3'd5,
    C_ERROR   = 3'd6,
    C_EOF     = 3'd7
  } tok_class_t;

  typedef enum logic [1:0] {
    RT_DATA = 2'd0,
    RT_END  = 2'd1,
    RT_ERR  = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_HEAD = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  // where the lexeme of the pending token comes from
  typedef enum logic [1:0] {
    SRC_PAIR  = 2'd0,
    SRC_BYTE  = 2'd1,
    SRC_MEM   = 2'd2,
    SRC_EMPTY = 2'd3
  } src_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_PRE   = 3'd1,
    S_FIXA  = 3'd2,
    S_FIXB  = 3'd3,
    S_RD    = 3'd4,
    S_LOAD  = 3'd5,
    S_EMPTY = 3'd6,
    S_FIXUP = 3'd7
  } seq_state_t;

  function automatic tok_class_t kind_class(tok_kind_t k);
    tok_class_t c;
    case (k)
      K_GET:     c = C_METHOD;
      K_PATH:    c = C_PATH;
      K_VERSION: c = C_VERSION;
      K_EOL:     c = C_EOL;
      K_EOH:     c = C_EOH;
      K_CHUNK:   c = C_CHARS;
      K_EOF:     c = C_EOF;
      default:   c = C_ERROR;
    endcase
    return c;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic [7:0] get_char(logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = "G";
      2'd1:    c = "E";
      2'd2:    c = "T";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ver_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = "H";
      3'd1:    c = "T";
      3'd2:    c = "T";
      3'd3:    c = "P";
      3'd4:    c = "/";
      3'd5:    c = "1";
      3'd6:    c = ".";
      3'd7:    c = "1";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic seq_state_t src_first(src_t s);
    seq_state_t st;
    case (s)
      SRC_PAIR:  st = S_FIXA;
      SRC_BYTE:  st = S_FIXB;
      SRC_MEM:   st = S_RD;
      SRC_EMPTY: st = S_EMPTY;
      default:   st = S_EMPTY;
    endcase
    return st;
  endfunction

endpackage

>>> hdl/hrlt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module hrlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/http_request_line_tokenizer.sv
// HTTP request line tokenizer: one input beat at a time, tokens out as runs of lexeme beats.
// Fixed bytes go from the input beat into the sequencer state, then the output register;
// each stored byte is read from the word store RAM, then loaded into the output register;
// both loads wait while the output is stalled. One input beat in flight at a time.
// Reset (rst_n low, synchronous) clears the sequencer, phase and flags; the word store is
// not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module http_request_line_tokenizer
  import hrlt_pkg::*;
#(
  parameter int LEXEME_BYTES = LEXEME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] lexeme_byte
  output logic [7:0] out_tuser,  // [3:0] token_kind, [6:4] token_class, [7] byte_valid
  output logic       out_tlast   // last_of_token
);

  localparam int AW  = $clog2(LEXEME_BYTES);
  localparam int WLW = $clog2(LEXEME_BYTES + 1);

  seq_state_t       state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic             cr_r, cr_nxt;
  logic             peol_r, peol_nxt;
  logic             ended_r, ended_nxt;
  logic             err_r, err_nxt;
  logic [WLW-1:0]   wl_r, wl_nxt;
  logic             slash_r, slash_nxt;
  logic             getok_r, getok_nxt;
  logic             verok_r, verok_nxt;
  tok_kind_t        kind_r, kind_nxt;
  src_t             src_r, src_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [WLW-1:0]   len_r, len_nxt;
  logic [WLW-1:0]   idx_r, idx_nxt;
  logic             fixup_r, fixup_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [3:0]       out_kind_r, out_kind_nxt;
  logic [2:0]       out_class_r, out_class_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_bv_r, out_bv_nxt;
  logic             out_last_r, out_last_nxt;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  logic             in_fire, out_free;
  logic [7:0]       b;
  logic             sp, wl_full, get_hit, ver_hit;
  tok_kind_t        word_kind;
  logic             go, pre;
  src_t             src_sel;
  tok_kind_t        kind_sel;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign b        = in_tdata;
  assign sp       = is_space(b);
  assign wl_full  = (wl_r == WLW'(LEXEME_BYTES - 1));
  assign get_hit  = (wl_r < WLW'(3)) && (b == get_char(wl_r[1:0]));
  assign ver_hit  = (wl_r < WLW'(8)) && (b == ver_char(wl_r[2:0]));

  always_comb begin
    if (slash_r) begin
      word_kind = K_PATH;
    end else if ((wl_r == WLW'(3)) && getok_r) begin
      word_kind = K_GET;
    end else if ((wl_r == WLW'(8)) && verok_r) begin
      word_kind = K_VERSION;
    end else begin
      word_kind = K_BAD_FIRST;
    end
  end

  hrlt_ram #(
    .WIDTH (8),
    .DEPTH (LEXEME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LINE;
      cr_r        <= 1'b0;
      peol_r      <= 1'b0;
      ended_r     <= 1'b0;
      err_r       <= 1'b0;
      wl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cr_r        <= cr_nxt;
      peol_r      <= peol_nxt;
      ended_r     <= ended_nxt;
      err_r       <= err_nxt;
      wl_r        <= wl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slash_r     <= slash_nxt;
    getok_r     <= getok_nxt;
    verok_r     <= verok_nxt;
    kind_r      <= kind_nxt;
    src_r       <= src_nxt;
    byte_r      <= byte_nxt;
    len_r       <= len_nxt;
    idx_r       <= idx_nxt;
    fixup_r     <= fixup_nxt;
    out_kind_r  <= out_kind_nxt;
    out_class_r <= out_class_nxt;
    out_byte_r  <= out_byte_nxt;
    out_bv_r    <= out_bv_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cr_nxt        = cr_r;
    peol_nxt      = peol_r;
    ended_nxt     = ended_r;
    err_nxt       = err_r;
    wl_nxt        = wl_r;
    slash_nxt     = slash_r;
    getok_nxt     = getok_r;
    verok_nxt     = verok_r;
    kind_nxt      = kind_r;
    src_nxt       = src_r;
    byte_nxt      = byte_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    fixup_nxt     = fixup_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_class_nxt = out_class_r;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = wl_r[AW-1:0];
    ram_wdata     = b;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[AW-1:0];
    in_tready     = 1'b0;
    go            = 1'b0;
    pre           = 1'b0;
    src_sel       = SRC_EMPTY;
    kind_sel      = K_EOF;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          byte_nxt  = b;
          len_nxt   = wl_r;
          fixup_nxt = 1'b0;
          if (ended_r) begin
            go       = 1'b1;
            src_sel  = SRC_EMPTY;
            kind_sel = err_r ? K_IO_ERR : K_EOF;
          end else if (in_tuser != RT_DATA) begin
            go        = 1'b1;
            pre       = cr_r;
            cr_nxt    = 1'b0;
            err_nxt   = (in_tuser != RT_END);
            kind_sel  = (in_tuser != RT_END) ? K_IO_ERR : K_EOF;
            src_sel   = (wl_r != '0) ? SRC_MEM : SRC_EMPTY;
            wl_nxt    = '0;
            ended_nxt = 1'b1;
          end else if (phase_r == PH_PAY) begin
            ram_we = 1'b1;
            wl_nxt = wl_r + WLW'(1);
            if (wl_full) begin
              go       = 1'b1;
              src_sel  = SRC_MEM;
              kind_sel = K_CHUNK;
              len_nxt  = WLW'(LEXEME_BYTES);
              wl_nxt   = '0;
            end
          end else if (cr_r) begin
            go       = 1'b1;
            cr_nxt   = 1'b0;
            src_sel  = SRC_PAIR;
            if (b != CH_LF) begin
              kind_sel = K_CRLF_ERR;
            end else if (peol_r) begin
              kind_sel  = K_EOH;
              phase_nxt = PH_PAY;
              wl_nxt    = '0;
            end else begin
              kind_sel  = K_EOL;
              phase_nxt = PH_HEAD;
            end
          end else if (wl_r != '0) begin
            if (sp) begin
              go       = 1'b1;
              src_sel  = SRC_MEM;
              kind_sel = word_kind;
              wl_nxt   = '0;
              cr_nxt   = (b == CH_CR);
            end else begin
              ram_we    = 1'b1;
              wl_nxt    = wl_r + WLW'(1);
              getok_nxt = getok_r && get_hit;
              verok_nxt = verok_r && ver_hit;
              if (wl_full) begin
                // last byte also opens the next word; store[0] rewritten after the read-out
                go        = 1'b1;
                src_sel   = SRC_MEM;
                kind_sel  = K_TOO_LONG;
                len_nxt   = WLW'(LEXEME_BYTES);
                fixup_nxt = 1'b1;
                wl_nxt    = WLW'(1);
                slash_nxt = (b == CH_SLASH);
                getok_nxt = (b == get_char(2'd0));
                verok_nxt = (b == ver_char(3'd0));
              end
            end
          end else if (b == CH_CR) begin
            cr_nxt = 1'b1;
          end else if (sp) begin
            cr_nxt = cr_r;
          end else if (phase_r == PH_LINE) begin
            ram_we    = 1'b1;
            wl_nxt    = WLW'(1);
            slash_nxt = (b == CH_SLASH);
            getok_nxt = get_hit;
            verok_nxt = ver_hit;
          end else begin
            go       = 1'b1;
            src_sel  = SRC_BYTE;
            kind_sel = K_BAD_CHAR;
          end

          if (go) begin
            kind_nxt  = kind_sel;
            src_nxt   = src_sel;
            idx_nxt   = '0;
            state_nxt = pre ? S_PRE : src_first(src_sel);
            if (!ended_r) begin
              peol_nxt = (kind_sel == K_EOL);
            end
          end
        end
      end

      S_PRE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_CRLF_ERR;
          out_class_nxt = kind_class(K_CRLF_ERR);
          out_byte_nxt  = CH_CR;
          out_bv_nxt    = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = src_first(src_r);
        end
      end

      S_FIXA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_class_nxt = kind_class(kind_r);
          out_byte_nxt  = CH_CR;
          out_bv_nxt    = 1'b1;
          out_last_nxt  = 1'b0;
          state_nxt     = S_FIXB;
        end
      end

      S_FIXB: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_class_nxt = kind_class(kind_r);
          out_byte_nxt  = byte_r;
          out_bv_nxt    = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_class_nxt = kind_class(kind_r);
          out_byte_nxt  = 8'h00;
          out_bv_nxt    = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_class_nxt = kind_class(kind_r);
          out_byte_nxt  = ram_rdata;
          out_bv_nxt    = 1'b1;
          out_last_nxt  = (idx_r == len_r - WLW'(1));
          idx_nxt       = idx_r + WLW'(1);
          if (idx_r == len_r - WLW'(1)) begin
            state_nxt = fixup_r ? S_FIXUP : S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_FIXUP: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = byte_r;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_bv_r, out_class_r, out_kind_r};
  assign out_tlast  = out_last_r;

  a_wl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wl_r <= WLW'(LEXEME_BYTES - 1))
    else $error("word length past store depth");

  a_pay_no_cr: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAY |-> !cr_r)
    else $error("CR pending in payload phase");

  a_head_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    wl_r != '0 |-> phase_r != PH_HEAD)
    else $error("word collected after first line");

  a_ended_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ended_r |=> state_r == S_EMPTY)
    else $error("beat after end of stream not answered with empty token");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[7] |-> out_tlast)
    else $error("empty lexeme beat not marked last");

endmodule
